/* design/utf8c_pkg.sv */
// utf8c_pkg: shared types and constants for the utf-8 safe text checker
// used by utf8c_step, utf8c_verdict and utf8_safe_text_checker
`default_nettype none

package utf8c_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 17;
    localparam int TOTAL_W  = 17;
    localparam int CODE_W   = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    localparam logic [BYTE_W-1:0] ASCII_MAX    = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_LO     = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI     = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO     = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI     = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO     = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI     = 8'hF4;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT   = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR      = 8'h0D;
    localparam logic [1:0]        CONT_TAG     = 2'b10;

    localparam logic [CODE_W-1:0] CP_MIN_2     = 21'h000080;
    localparam logic [CODE_W-1:0] CP_MIN_3     = 21'h000800;
    localparam logic [CODE_W-1:0] CP_MIN_4     = 21'h010000;
    localparam logic [CODE_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI      = 21'h00DFFF;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_class_t;

    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_EMPTY   = 3'd1,
        FAULT_LENGTH  = 3'd2,
        FAULT_UTF8    = 3'd3,
        FAULT_CONTROL = 3'd4
    } fault_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH_LIMIT = 2'd0,
        CFG_EMPTY_OK     = 2'd1,
        CFG_BREAKS_OK    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        cont_left;
        logic [CODE_W-1:0] code;
        seq_class_t        seq_class;
        logic              utf8_fault;
        logic              ctrl_fault;
    } text_state_t;

endpackage

`default_nettype wire

/* design/utf8_safe_text_checker.sv */
// Checks a text arriving one byte per request for strict utf-8 and safe characters and
// returns one verdict request on the item marked last. A new byte is taken every clock
// cycle unless a last byte waits behind an unread verdict; a verdict goes from the input
// register via the per-byte decoder update into the result register. Throughput is limited
// only by the output side: while a verdict waits unread, bytes that are not last still
// flow. Configuration writes are always ready and are meant for idle times between texts.
// utf8_safe_text_checker: top level, depends on utf8c_pkg, utf8c_step and utf8c_verdict
`default_nettype none

module utf8_safe_text_checker
#(
    parameter int LIMIT_MAX = 65536
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [utf8c_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    input  wire logic                               s_axis_tuser,   // [0] has_byte
    input  wire logic                               s_axis_tlast,   // last_byte

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [utf8c_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // [0] text_ok,
                                                                    // [3:1] fault_kind,
                                                                    // [20:4] byte_total

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [utf8c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [utf8c_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(LIMIT_MAX + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(LIMIT_MAX + 1);

    logic [utf8c_pkg::LIMIT_W-1:0] limit_reg;
    logic                          empty_ok_reg;
    logic                          breaks_ok_reg;

    logic                          in_valid_reg;
    logic [utf8c_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          in_has_reg;
    logic                          in_last_reg;

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    utf8c_pkg::text_state_t        st_reg;
    utf8c_pkg::text_state_t        st_next;
    utf8c_pkg::text_state_t        st_step;

    logic                          out_valid_reg;
    logic                          out_ok_reg;
    utf8c_pkg::fault_kind_t        out_kind_reg;
    logic [utf8c_pkg::TOTAL_W-1:0] out_total_reg;

    utf8c_pkg::fault_kind_t        kind;
    logic                          out_free;
    logic                          consume;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || consume;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_total_reg, out_kind_reg, out_ok_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= utf8c_pkg::LIMIT_RESET;
            empty_ok_reg  <= 1'b0;
            breaks_ok_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                utf8c_pkg::CFG_LENGTH_LIMIT: limit_reg     <= cfg_data;
                utf8c_pkg::CFG_EMPTY_OK:     empty_ok_reg  <= cfg_data[0];
                utf8c_pkg::CFG_BREAKS_OK:    breaks_ok_reg <= cfg_data[0];
                default:                     limit_reg     <= limit_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata[utf8c_pkg::BYTE_W-1:0];
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
    end

    utf8c_step u_step
    (
        .text_byte (in_byte_reg),
        .breaks_ok (breaks_ok_reg),
        .st_in     (st_reg),
        .st_out    (st_step)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        st_next  = st_reg;
        if (in_has_reg)
        begin
            if (cnt_reg != CNT_SAT)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            st_next = st_step;
        end
    end

    utf8c_verdict #(
        .LIMIT_MAX (LIMIT_MAX),
        .CNT_W     (CNT_W)
    ) u_verdict
    (
        .byte_count   (cnt_next),
        .length_limit (limit_reg),
        .empty_ok     (empty_ok_reg),
        .st           (st_next),
        .kind         (kind)
    );

    // text state, cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            st_reg  <= '0;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                cnt_reg <= '0;
                st_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                st_reg  <= st_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_ok_reg    <= (kind == utf8c_pkg::FAULT_NONE);
            out_kind_reg  <= kind;
            out_total_reg <= utf8c_pkg::TOTAL_W'(cnt_next);
        end
    end

endmodule

`default_nettype wire

/* design/utf8c_step.sv */
// utf8c_step: per-byte update of the utf-8 decoder and control byte flags
// depends on utf8c_pkg
`default_nettype none

module utf8c_step
(
    input  wire logic [utf8c_pkg::BYTE_W-1:0] text_byte,
    input  wire logic                         breaks_ok,
    input  wire utf8c_pkg::text_state_t       st_in,
    output utf8c_pkg::text_state_t            st_out
);

    logic [utf8c_pkg::CODE_W-1:0] code_shift;
    logic [utf8c_pkg::CODE_W-1:0] least;
    logic [1:0]                   cont_dec;
    logic                         is_break;

    assign code_shift = {st_in.code[utf8c_pkg::CODE_W-7:0], text_byte[5:0]};
    assign cont_dec   = st_in.cont_left - 2'd1;
    assign is_break   = (text_byte == utf8c_pkg::BYTE_TAB) || (text_byte == utf8c_pkg::BYTE_LF)
                        || (text_byte == utf8c_pkg::BYTE_CR);

    always_comb
    begin
        case (st_in.seq_class)
            utf8c_pkg::SEQ_TWO:   least = utf8c_pkg::CP_MIN_2;
            utf8c_pkg::SEQ_THREE: least = utf8c_pkg::CP_MIN_3;
            default:              least = utf8c_pkg::CP_MIN_4;
        endcase
    end

    always_comb
    begin
        st_out = st_in;
        if (st_in.cont_left == 2'd0)
        begin
            if (text_byte <= utf8c_pkg::ASCII_MAX)
            begin
                st_out = st_in;
            end
            else if (text_byte inside {[utf8c_pkg::LEAD2_LO:utf8c_pkg::LEAD2_HI]})
            begin
                st_out.cont_left = 2'd1;
                st_out.code      = {16'd0, text_byte[4:0]};
                st_out.seq_class = utf8c_pkg::SEQ_TWO;
            end
            else if (text_byte inside {[utf8c_pkg::LEAD3_LO:utf8c_pkg::LEAD3_HI]})
            begin
                st_out.cont_left = 2'd2;
                st_out.code      = {17'd0, text_byte[3:0]};
                st_out.seq_class = utf8c_pkg::SEQ_THREE;
            end
            else if (text_byte inside {[utf8c_pkg::LEAD4_LO:utf8c_pkg::LEAD4_HI]})
            begin
                st_out.cont_left = 2'd3;
                st_out.code      = {18'd0, text_byte[2:0]};
                st_out.seq_class = utf8c_pkg::SEQ_FOUR;
            end
            else
            begin
                st_out.utf8_fault = 1'b1;
            end
        end
        else if (text_byte[7:6] != utf8c_pkg::CONT_TAG)
        begin
            // broken sequence, byte is not reused as a lead
            st_out.utf8_fault = 1'b1;
            st_out.cont_left  = 2'd0;
            st_out.code       = '0;
            st_out.seq_class  = utf8c_pkg::SEQ_NONE;
        end
        else if (cont_dec != 2'd0)
        begin
            st_out.cont_left = cont_dec;
            st_out.code      = code_shift;
        end
        else
        begin
            st_out.cont_left = 2'd0;
            st_out.code      = '0;
            st_out.seq_class = utf8c_pkg::SEQ_NONE;
            if ((code_shift < least) || (code_shift > utf8c_pkg::CP_MAX)
                || ((code_shift >= utf8c_pkg::SURR_LO) && (code_shift <= utf8c_pkg::SURR_HI)))
            begin
                st_out.utf8_fault = 1'b1;
            end
        end

        if ((text_byte < utf8c_pkg::CTRL_LIMIT) && !(breaks_ok && is_break))
        begin
            st_out.ctrl_fault = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/utf8c_verdict.sv */
// utf8c_verdict: ranks the faults of a finished text into one fault kind
// depends on utf8c_pkg
`default_nettype none

module utf8c_verdict
#(
    parameter int LIMIT_MAX = 65536,
    parameter int CNT_W     = 17
)
(
    input  wire logic [CNT_W-1:0]              byte_count,
    input  wire logic [utf8c_pkg::LIMIT_W-1:0] length_limit,
    input  wire logic                          empty_ok,
    input  wire utf8c_pkg::text_state_t        st,
    output utf8c_pkg::fault_kind_t             kind
);

    logic [31:0] limit_wide;
    logic [31:0] limit_eff;
    logic [31:0] count_wide;

    assign limit_wide = 32'(length_limit);
    assign limit_eff  = (limit_wide > 32'(LIMIT_MAX)) ? 32'(LIMIT_MAX) : limit_wide;
    assign count_wide = 32'(byte_count);

    always_comb
    begin
        if ((byte_count == '0) && !empty_ok)
        begin
            kind = utf8c_pkg::FAULT_EMPTY;
        end
        else if (count_wide > limit_eff)
        begin
            kind = utf8c_pkg::FAULT_LENGTH;
        end
        else if (st.utf8_fault || (st.cont_left != 2'd0))
        begin
            kind = utf8c_pkg::FAULT_UTF8;
        end
        else if (st.ctrl_fault)
        begin
            kind = utf8c_pkg::FAULT_CONTROL;
        end
        else
        begin
            kind = utf8c_pkg::FAULT_NONE;
        end
    end

endmodule

`default_nettype wire
